### design/cbp_pkg.sv
`default_nettype none

package cbp_pkg;

	// Section header occupies bytes 0..7; blocks start right after it
	localparam logic [32:0] FIRST_HDR_OFF = 33'd8;

	// Result queue geometry
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = 2;

	// Register reset values
	localparam logic [15:0] POLY_RESET = 16'h1f45;
	localparam logic [15:0] INIT_RESET = 16'h8320;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_POLY = 1'b0,
		CFG_INIT = 1'b1
	} cfg_index_t;

	typedef enum logic [0:0] {
		KIND_BLOCK  = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	// Section status codes; when several apply, the order of checks in the parser decides
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_HDR_TRUNC = 3'd1,
		ST_WINDOW    = 3'd2,
		ST_BAD_CRC   = 3'd3,
		ST_TOO_MANY  = 3'd4,
		ST_HDR_PAST  = 3'd5,
		ST_DATA_PAST = 3'd6,
		ST_NEG_LEN   = 3'd7
	} status_t;

	// One result record as it leaves the block
	typedef struct packed {
		kind_t        kind;
		logic [31:0]  block_type;
		logic [20:0]  block_length;
		logic [20:0]  data_offset;
		logic [4:0]   block_index;
		status_t      status;
		logic [5:0]   blocks_found;
		logic [15:0]  checksum;
		logic         last;
	} rec_t;

endpackage

`default_nettype wire

### design/cbp_crc_byte.sv
`default_nettype none

// One byte of a shift-left CRC-16, eight bit steps unrolled
module cbp_crc_byte (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	input  wire logic [15:0] poly,
	output logic      [15:0] crc_out
);

	always_comb begin
		logic [15:0] r;
		r = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ poly;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		crc_out = r;
	end

endmodule

`default_nettype wire

### design/cbp_out_fifo.sv
`default_nettype none

// Small result queue: takes up to two records a cycle, hands out one
module cbp_out_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [1:0]          push_cnt,
	input  wire cbp_pkg::rec_t       push_a,
	input  wire cbp_pkg::rec_t       push_b,
	output logic                     room_two,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output cbp_pkg::rec_t            out_rec
);

	localparam int unsigned PW = cbp_pkg::FIFO_PTR_W;

	cbp_pkg::rec_t mem_q [cbp_pkg::FIFO_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_rec   = mem_q[rd_q];
	assign room_two  = (cnt_q <= (PW+1)'(cbp_pkg::FIFO_DEPTH - 2));

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= push_a;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_q + 1'b1] <= push_b;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push_cnt);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + (PW+1)'(push_cnt) - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

### design/checksummed_block_list_parser_core.sv
// Checksummed block list parser.
// Input channel (in_valid/in_ready): one section byte per transfer, with
// end_of_section high on the last byte. Bytes 0..7 carry the little-endian
// window length and stored checksum; from byte 8 a CRC-16 runs over the
// window and type/length block headers are walked until type -1.
// Output channel (out_valid/out_ready): a block record per parsed header,
// then one status record (last = 1) per section. Records with a non-zero
// section status are to be discarded by the consumer.
// Config channel (cfg_valid/cfg_ready): index 0 polynomial, index 1 initial
// value; always ready. It must be written only while idle; the block does not enforce this.
// Path: a byte passes the input register, then the parse logic writes its
// records into the result queue, which offers them; the byte waits in the
// input register while the queue has no room for two records.
// Throughput: one byte per cycle while the queue has room for two records; a
// closing byte that also completes a header yields two records. The rate is
// set by the single parse stage and the one-record-per-cycle queue read.
// Reset: state and configuration registers return to their defaults and a fresh section begins.
// Receiver stall: the four-entry queue absorbs records; the input stage
// holds its byte while fewer than two queue entries are free.
`default_nettype none

module checksummed_block_list_parser_core #(
	parameter int MAX_BLOCK_COUNT   = 32,
	parameter int MAX_SECTION_BYTES = 1048576
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_section,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             record_kind,
	output logic signed [31:0] block_type,
	output logic [20:0]      block_length,
	output logic [20:0]      data_offset,
	output logic [4:0]       block_index,
	output logic [2:0]       status,
	output logic [5:0]       blocks_found,
	output logic [15:0]      computed_checksum,
	output logic             last
);

	localparam int POS_W = $clog2(MAX_SECTION_BYTES + 1);
	localparam int CNT_W = $clog2(MAX_BLOCK_COUNT + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SECTION_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_COUNT);
	localparam logic [31:0]      LEN_MAX = 32'(MAX_SECTION_BYTES);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BLOCKS,
		PH_DONE
	} phase_t;

	// Configuration registers
	logic [15:0] poly_q;
	logic [15:0] init_q;

	// Input stage
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        go;

	// Section state
	logic [POS_W-1:0]      pos_q, pos_d;
	phase_t                phase_q, phase_d;
	logic [31:0]           wa_q, wa_d;
	logic [31:0]           wl_q, wl_d;
	logic [31:0]           sc_q, sc_d;
	logic [15:0]           crc_q, crc_d;
	logic [31:0]           pt_q, pt_d;
	logic [32:0]           nh_q, nh_d;
	logic [32:0]           de_q, de_d;
	logic [CNT_W-1:0]      seen_q, seen_d;
	cbp_pkg::status_t      err_q, err_d;
	logic                  term_q, term_d;

	logic [15:0]           crc_step;
	logic                  blk_emit;
	cbp_pkg::rec_t         rec_b;
	cbp_pkg::rec_t         rec_s;
	logic [1:0]            push_cnt;
	logic                  room_two;
	cbp_pkg::rec_t         out_rec;

	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= cbp_pkg::POLY_RESET;
			init_q <= cbp_pkg::INIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cbp_pkg::cfg_index_t'(cfg_index))
				cbp_pkg::CFG_POLY: poly_q <= cfg_data;
				cbp_pkg::CFG_INIT: init_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: advances when the queue can take two records
	assign go       = v_s1 && room_two;
	assign in_ready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			end_s1  <= end_of_section;
		end
	end

	cbp_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (byte_s1),
		.poly    (poly_q),
		.crc_out (crc_step)
	);

	// Parse one byte and build its records
	always_comb begin
		logic        in_win;
		logic [32:0] pos_ext;
		logic [32:0] hdr_diff;
		logic        hdr_hit;
		logic [31:0] shown;
		cbp_pkg::status_t st;

		pos_d    = pos_q;
		phase_d  = phase_q;
		wa_d     = wa_q;
		wl_d     = wl_q;
		sc_d     = sc_q;
		crc_d    = crc_q;
		pt_d     = pt_q;
		nh_d     = nh_q;
		de_d     = de_q;
		seen_d   = seen_q;
		err_d    = err_q;
		term_d   = term_q;
		blk_emit = 1'b0;
		in_win   = (pos_q < POS_MAX);
		pos_ext  = 33'(pos_q);
		hdr_diff = pos_ext - nh_q;
		hdr_hit  = 1'b0;
		shown    = (wa_d > LEN_MAX) ? LEN_MAX : wa_d;

		if (in_win) begin
			pos_d = pos_q + 1'b1;
			wa_d  = {byte_s1, wa_q[31:8]};
			if (pos_q < POS_W'(8)) begin
				if (pos_q == POS_W'(3)) begin
					wl_d = wa_d;
				end
				if (pos_q == POS_W'(7)) begin
					sc_d    = wa_d;
					phase_d = PH_BLOCKS;
				end
			end else begin
				// CRC only inside a non-negative window
				if (!wl_q[31] && ((32'(pos_q) - 32'd8) < wl_q)) begin
					crc_d = crc_step;
				end
				hdr_hit = (phase_q == PH_BLOCKS) && (seen_q < CNT_MAX) &&
				          (pos_ext >= nh_q) && (hdr_diff < 33'd8);
				if (hdr_hit && hdr_diff[2:0] == 3'd3) begin
					pt_d = wa_d;
				end
				if (hdr_hit && hdr_diff[2:0] == 3'd7) begin
					if (pt_q == 32'hffff_ffff) begin
						term_d  = 1'b1;
						phase_d = PH_DONE;
					end else if (wa_d[31]) begin
						err_d   = cbp_pkg::ST_NEG_LEN;
						phase_d = PH_DONE;
					end else begin
						blk_emit = 1'b1;
						de_d     = nh_q + 33'd8 + 33'(wa_d);
						nh_d     = (nh_q + 33'd11 + 33'(wa_d)) & ~33'd3;
						seen_d   = seen_q + 1'b1;
					end
				end
			end
		end
		shown = (wa_d > LEN_MAX) ? LEN_MAX : wa_d;

		// Block record
		rec_b              = '0;
		rec_b.kind         = cbp_pkg::KIND_BLOCK;
		rec_b.block_type   = pt_q;
		rec_b.block_length = 21'(shown);
		rec_b.data_offset  = 21'(nh_q + 33'd8);
		rec_b.block_index  = 5'(seen_q);

		// Section status, first failing check wins
		if (pos_d < POS_W'(8)) begin
			st = cbp_pkg::ST_HDR_TRUNC;
		end else if (!wl_d[31] && (33'd8 + 33'(wl_d) > 33'(pos_d))) begin
			st = cbp_pkg::ST_WINDOW;
		end else if (32'(crc_d) != sc_d) begin
			st = cbp_pkg::ST_BAD_CRC;
		end else if (term_d) begin
			st = cbp_pkg::ST_OK;
		end else if (err_d != cbp_pkg::ST_OK) begin
			st = err_d;
		end else if (de_d > 33'(pos_d)) begin
			st = cbp_pkg::ST_DATA_PAST;
		end else if (seen_d >= CNT_MAX) begin
			st = cbp_pkg::ST_TOO_MANY;
		end else begin
			st = cbp_pkg::ST_HDR_PAST;
		end

		rec_s              = '0;
		rec_s.kind         = cbp_pkg::KIND_STATUS;
		rec_s.status       = st;
		rec_s.blocks_found = 6'(seen_d);
		rec_s.checksum     = crc_d;
		rec_s.last         = 1'b1;

		// Closing byte restarts the section
		if (end_s1) begin
			pos_d   = '0;
			phase_d = PH_HEADER;
			wa_d    = '0;
			wl_d    = '0;
			sc_d    = '0;
			crc_d   = init_q;
			pt_d    = '0;
			nh_d    = cbp_pkg::FIRST_HDR_OFF;
			de_d    = cbp_pkg::FIRST_HDR_OFF;
			seen_d  = '0;
			err_d   = cbp_pkg::ST_OK;
			term_d  = 1'b0;
		end
	end

	// Section state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_HEADER;
			wa_q    <= '0;
			wl_q    <= '0;
			sc_q    <= '0;
			crc_q   <= cbp_pkg::INIT_RESET;
			pt_q    <= '0;
			nh_q    <= cbp_pkg::FIRST_HDR_OFF;
			de_q    <= cbp_pkg::FIRST_HDR_OFF;
			seen_q  <= '0;
			err_q   <= cbp_pkg::ST_OK;
			term_q  <= 1'b0;
		end else if (go) begin
			pos_q   <= pos_d;
			phase_q <= phase_d;
			wa_q    <= wa_d;
			wl_q    <= wl_d;
			sc_q    <= sc_d;
			crc_q   <= crc_d;
			pt_q    <= pt_d;
			nh_q    <= nh_d;
			de_q    <= de_d;
			seen_q  <= seen_d;
			err_q   <= err_d;
			term_q  <= term_d;
		end
	end

	// Records into the queue, block record ahead of the status
	assign push_cnt = go ? (2'(blk_emit) + 2'(end_s1)) : 2'd0;

	cbp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_a    (blk_emit ? rec_b : rec_s),
		.push_b    (rec_s),
		.room_two  (room_two),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rec   (out_rec)
	);

	assign record_kind       = out_rec.kind;
	assign block_type        = out_rec.block_type;
	assign block_length      = out_rec.block_length;
	assign data_offset       = out_rec.data_offset;
	assign block_index       = out_rec.block_index;
	assign status            = out_rec.status;
	assign blocks_found      = out_rec.blocks_found;
	assign computed_checksum = out_rec.checksum;
	assign last              = out_rec.last;

`ifndef SYNTHESIS
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == record_kind))
		else $error("last flag and record kind disagree");

	a_section_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(go && end_s1) |=> (pos_q == '0 && seen_q == '0))
		else $error("section state not cleared after closing byte");

	a_offset_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !record_kind) |-> (data_offset[1:0] == 2'b00))
		else $error("block data offset not word aligned");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position beyond section limit");
`endif

endmodule

`default_nettype wire
